FILE: rtl/core/trsc_pkg.sv
package trsc_pkg;

  localparam int ENTRY_W = 5;
  localparam int CHAR_W  = 8;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_ENCIPHER = 1'b1;

  localparam logic [1:0] ROTOR_FIRST  = 2'd0;
  localparam logic [1:0] ROTOR_SECOND = 2'd1;
  localparam logic [1:0] ROTOR_THIRD  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;

  // One request as it moves down the rotor pipeline.
  typedef struct packed {
    logic               is_load;
    logic [1:0]         rotor_select;
    logic [ENTRY_W-1:0] entry_index;
    logic [ENTRY_W-1:0] entry_value;
    logic               is_letter;
    logic               is_lower;
    logic [CHAR_W-1:0]  char_in;
    logic [ENTRY_W-1:0] middle_offset;
    logic [ENTRY_W-1:0] slow_offset;
  } trsc_stage_t;

endpackage

FILE: rtl/core/trsc_rotor_ram.sv
module trsc_rotor_ram #(
  parameter int DEPTH = 26
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [trsc_pkg::ENTRY_W-1:0]      wdata,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [trsc_pkg::ENTRY_W-1:0]      rdata
);

  logic [trsc_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds while re is low, so a stalled stage keeps its value.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/three_rotor_substitution_cipher.sv
// Three-rotor substitution cipher without a reflector.
// Input channel: in_valid / in_stall carry one request per accepted edge.
// action selects a rotor table load (rotor_select, entry_index, entry_value)
// or the encipherment of char_in. Output channel: out_valid / out_stall carry
// char_out, one result per encipher request; loads give no result.
// Each rotor table sits in its own synchronous RAM; a request reads rotor one,
// two and three in three successive pipeline stages, and a load writes its
// table in the stage where that table is read, so all accesses to one table
// stay in request order.
// The request is registered in stages p1, p2 and p3, and out_valid is p3_valid.
// Throughput: one request per cycle while out_stall is low, set by
// the single read port of each rotor RAM.
// When the receiver stalls, the output holds; requests still enter while the
// pipeline has an empty stage, and in_stall rises only when all three stages
// are full behind a stalled result.
// Reset clears the pipeline and the three offsets; the rotor tables are not
// cleared and must be loaded before use. No clearing pass is needed.
module three_rotor_substitution_cipher #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [1:0]                    rotor_select,
  input  logic [4:0]                    entry_index,
  input  logic [4:0]                    entry_value,
  input  logic [7:0]                    char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    char_out
);

  localparam int AW      = $clog2(ALPHABET_SIZE);
  localparam int SUM_W   = trsc_pkg::ENTRY_W + 1;
  localparam int LUT_N   = 2 ** SUM_W;
  localparam logic [trsc_pkg::ENTRY_W-1:0] LAST_OFS = trsc_pkg::ENTRY_W'(ALPHABET_SIZE - 1);
  localparam logic [trsc_pkg::ENTRY_W-1:0] SIZE_W   = trsc_pkg::ENTRY_W'(ALPHABET_SIZE);

  // Reduction table for sums below twice 32; built from constants only.
  logic [AW-1:0] mod_lut [LUT_N];
  always_comb begin
    for (int i = 0; i < LUT_N; i++) begin
      mod_lut[i] = AW'(i % ALPHABET_SIZE);
    end
  end

  logic [trsc_pkg::ENTRY_W-1:0] fast_offset;
  logic [trsc_pkg::ENTRY_W-1:0] middle_offset;
  logic [trsc_pkg::ENTRY_W-1:0] slow_offset;

  logic                  p1_valid;
  logic                  p2_valid;
  logic                  p3_valid;
  trsc_pkg::trsc_stage_t p1;
  trsc_pkg::trsc_stage_t p2;
  trsc_pkg::trsc_stage_t p3;
  trsc_pkg::trsc_stage_t in_item;

  logic ready1;
  logic ready2;
  logic ready3;
  logic accept;
  logic p1_move;
  logic p2_move;

  logic                         is_lower;
  logic                         is_upper;
  logic [7:0]                   letter_diff;
  logic [trsc_pkg::ENTRY_W-1:0] rd1;
  logic [trsc_pkg::ENTRY_W-1:0] rd2;
  logic [trsc_pkg::ENTRY_W-1:0] rd3;
  logic [AW-1:0]                raddr1;
  logic [AW-1:0]                raddr2;
  logic [AW-1:0]                raddr3;
  logic                         we1;
  logic                         we2;
  logic                         we3;
  logic [7:0]                   base;

  assign ready3   = !p3_valid || !out_stall;
  assign ready2   = !p2_valid || ready3;
  assign ready1   = !p1_valid || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;
  assign p1_move  = p1_valid && ready2;
  assign p2_move  = p2_valid && ready3;

  assign is_lower = (char_in >= trsc_pkg::CHAR_LOWER_A) && (char_in <= trsc_pkg::CHAR_LOWER_Z);
  assign is_upper = (char_in >= trsc_pkg::CHAR_UPPER_A) && (char_in <= trsc_pkg::CHAR_UPPER_Z);
  assign letter_diff = char_in - (is_lower ? trsc_pkg::CHAR_LOWER_A : trsc_pkg::CHAR_UPPER_A);

  always_comb begin
    in_item               = '0;
    in_item.is_load       = (action == trsc_pkg::ACT_LOAD);
    in_item.rotor_select  = rotor_select;
    in_item.entry_index   = entry_index;
    in_item.entry_value   = entry_value;
    in_item.is_letter     = is_lower || is_upper;
    in_item.is_lower      = is_lower;
    in_item.char_in       = char_in;
    in_item.middle_offset = middle_offset;
    in_item.slow_offset   = slow_offset;
  end

  // Table writes happen in the stage that reads the same table.
  assign we1 = accept && in_item.is_load && (rotor_select == trsc_pkg::ROTOR_FIRST)
               && (entry_index < SIZE_W);
  assign we2 = p1_move && p1.is_load && (p1.rotor_select == trsc_pkg::ROTOR_SECOND)
               && (p1.entry_index < SIZE_W);
  assign we3 = p2_move && p2.is_load && (p2.rotor_select == trsc_pkg::ROTOR_THIRD)
               && (p2.entry_index < SIZE_W);

  assign raddr1 = mod_lut[{1'b0, letter_diff[trsc_pkg::ENTRY_W-1:0]} + {1'b0, fast_offset}];
  assign raddr2 = mod_lut[{1'b0, rd1} + {1'b0, p1.middle_offset}];
  assign raddr3 = mod_lut[{1'b0, rd2} + {1'b0, p2.slow_offset}];

  trsc_rotor_ram #(.DEPTH(ALPHABET_SIZE)) u_rotor1 (
    .clk   (clk),
    .we    (we1),
    .waddr (entry_index[AW-1:0]),
    .wdata (entry_value),
    .re    (accept),
    .raddr (raddr1),
    .rdata (rd1)
  );

  trsc_rotor_ram #(.DEPTH(ALPHABET_SIZE)) u_rotor2 (
    .clk   (clk),
    .we    (we2),
    .waddr (p1.entry_index[AW-1:0]),
    .wdata (p1.entry_value),
    .re    (p1_move),
    .raddr (raddr2),
    .rdata (rd2)
  );

  trsc_rotor_ram #(.DEPTH(ALPHABET_SIZE)) u_rotor3 (
    .clk   (clk),
    .we    (we3),
    .waddr (p2.entry_index[AW-1:0]),
    .wdata (p2.entry_value),
    .re    (p2_move),
    .raddr (raddr3),
    .rdata (rd3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid      <= 1'b0;
      p2_valid      <= 1'b0;
      p3_valid      <= 1'b0;
      fast_offset   <= '0;
      middle_offset <= '0;
      slow_offset   <= '0;
    end else begin
      if (ready1) begin
        p1_valid <= in_valid;
      end
      if (ready2) begin
        p2_valid <= p1_valid;
      end
      // Loads are finished once the third table is written and leave no result.
      if (ready3) begin
        p3_valid <= p2_valid && !p2.is_load;
      end
      if (accept && !in_item.is_load && in_item.is_letter) begin
        if (fast_offset != LAST_OFS) begin
          fast_offset <= fast_offset + 1'b1;
        end else begin
          fast_offset <= '0;
          if (middle_offset != LAST_OFS) begin
            middle_offset <= middle_offset + 1'b1;
          end else begin
            middle_offset <= '0;
            if (slow_offset != LAST_OFS) begin
              slow_offset <= slow_offset + 1'b1;
            end else begin
              slow_offset <= '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= in_item;
    end
    if (p1_move) begin
      p2 <= p1;
    end
    if (p2_move) begin
      p3 <= p2;
    end
  end

  assign base      = p3.is_lower ? trsc_pkg::CHAR_LOWER_A : trsc_pkg::CHAR_UPPER_A;
  assign out_valid = p3_valid;
  assign char_out  = p3.is_letter ? 8'(base + {3'b000, rd3}) : p3.char_in;

endmodule

FILE: rtl/core/trsc_checker.sv
module trsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       action,
  input logic [7:0] char_in,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_out
);

  logic non_letter;
  assign non_letter = !((char_in >= trsc_pkg::CHAR_LOWER_A) && (char_in <= trsc_pkg::CHAR_LOWER_Z))
                   && !((char_in >= trsc_pkg::CHAR_UPPER_A) && (char_in <= trsc_pkg::CHAR_UPPER_Z));

  // The input side backs up only behind a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall high without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(char_out)))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // A non-letter passes unchanged through the pipeline when the receiver keeps up.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (action == trsc_pkg::ACT_ENCIPHER) && non_letter)
      ##1 !out_stall ##1 !out_stall
    |=> (out_valid && (char_out == $past(char_in, 3))))
    else $error("non-letter request not passed through");

endmodule

bind three_rotor_substitution_cipher trsc_checker u_trsc_checker (.*);
